// ===== rtl/double_ema_filter_assert.svh =====
// -----------------------------------------------------------------------------
// Double EMA filter assertion macros
// Shared property forms for the filter's internal checks. Every user of these
// macros has signals named clock and reset in scope.
// -----------------------------------------------------------------------------
`ifndef DOUBLE_EMA_FILTER_ASSERT_SVH
`define DOUBLE_EMA_FILTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DEMA_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DEMA_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/dema_pkg.sv =====
// -----------------------------------------------------------------------------
// Double EMA filter package
// Constants, register indexes and the command and status bundles shared by
// the controller and the datapath.
// -----------------------------------------------------------------------------
package dema_pkg;

   // Default sample width (signed Q15.16).
   localparam int DEFAULT_SAMPLE_WIDTH = 32;

   // Fraction bits of all fixed point values.
   localparam int FRAC_BITS = 16;

   // Register widths.
   localparam int PERIOD_WIDTH = 11;
   localparam int COEF_WIDTH   = 17;

   // Largest seed period; longer periods are clamped to it.
   localparam logic [PERIOD_WIDTH-1:0] MAX_PERIOD = PERIOD_WIDTH'(1024);

   // One in Q1.16; coefficients saturate here.
   localparam logic [COEF_WIDTH-1:0] ONE_Q16 = COEF_WIDTH'(65536);

   // Register reset values.
   localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET    = PERIOD_WIDTH'(30);
   localparam logic [COEF_WIDTH-1:0]   ALPHA_RESET     = COEF_WIDTH'(4228);
   localparam logic [COEF_WIDTH-1:0]   INV_PERIOD_RESET = COEF_WIDTH'(2185);

   // Register indexes (byte address divided by four).
   localparam int REG_INDEX_WIDTH = 2;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_PERIOD     = 2'd0;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_ALPHA      = 2'd1;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_INV_PERIOD = 2'd2;

   // Configuration port widths.
   localparam int ADDR_WIDTH = REG_INDEX_WIDTH + 2;
   localparam int DATA_WIDTH = 32;

   // Stage select codes.
   localparam logic STAGE_ONE = 1'b0;
   localparam logic STAGE_TWO = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;      // latch the accepted input beat
      logic prep;      // advance count and sum, set up multiplier operands
      logic mul;       // register the product
      logic rnd;       // round, saturate and write the stage EMA
      logic stage;     // stage that prep and rnd work on
      logic load_out;  // load the result register
      logic out_ok;    // the loaded result is valid
   } dema_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sample_ok;  // latched sample is a number
      logic seeded;     // selected stage already counts as seeded
      logic seed_now;   // selected stage reaches its period with this value
      logic out_busy;   // result register holds a beat that is not taken
   } dema_stat_type;

endpackage

// ===== rtl/dema_req_if.sv =====
// -----------------------------------------------------------------------------
// Double EMA filter input channel
// Valid/ready channel that carries one sample and its validity flag per beat.
// -----------------------------------------------------------------------------
interface dema_req_if #(
   parameter int SAMPLE_WIDTH = dema_pkg::DEFAULT_SAMPLE_WIDTH
) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;
   logic                           sample_valid;

   modport source (output valid, output sample, output sample_valid, input ready);
   modport sink   (input valid, input sample, input sample_valid, output ready);
endinterface

// ===== rtl/dema_rsp_if.sv =====
// -----------------------------------------------------------------------------
// Double EMA filter result channel
// Valid/ready channel that carries one DEMA value and its validity flag per beat.
// -----------------------------------------------------------------------------
interface dema_rsp_if #(
   parameter int SAMPLE_WIDTH = dema_pkg::DEFAULT_SAMPLE_WIDTH
) ();
   logic                             valid;
   logic                             ready;
   logic signed [SAMPLE_WIDTH+1:0]   dema_value;
   logic                             dema_valid;

   modport source (output valid, output dema_value, output dema_valid, input ready);
   modport sink   (input valid, input dema_value, input dema_valid, output ready);
endinterface

// ===== rtl/double_ema_filter.sv =====
// A valid item passes through each of the two EMA stages in three steps (operand
// setup, multiply, round) on the one shared multiplier; then the result register
// is loaded once it is free, and only then is the next sample accepted.
// An invalid sample, or a stage still seeding, ends the sequence early.
// Synchronous active-high reset clears counts, sums and EMAs and restores registers.
// -----------------------------------------------------------------------------
// Double EMA filter top level
// DEMA over signed Q15.16 samples with NaN skipping, seeded means and APB-style
// configuration of period, alpha and period reciprocal.
// -----------------------------------------------------------------------------
module double_ema_filter #(
   parameter int SAMPLE_WIDTH = dema_pkg::DEFAULT_SAMPLE_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [dema_pkg::ADDR_WIDTH-1:0]  paddr,
   input  logic [dema_pkg::DATA_WIDTH-1:0]  pwdata,
   output logic [dema_pkg::DATA_WIDTH-1:0]  prdata,
   output logic                             pready,
   dema_req_if.sink                         req_bus,
   dema_rsp_if.source                       rsp_bus
);

   logic [dema_pkg::PERIOD_WIDTH-1:0] period_length;
   logic [dema_pkg::COEF_WIDTH-1:0]   alpha_q16;
   logic [dema_pkg::COEF_WIDTH-1:0]   inv_period_q16;
   dema_pkg::dema_cmd_type            cmd;
   dema_pkg::dema_stat_type           stat;

   // Configuration registers.
   dema_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .period_length  (period_length),
      .alpha_q16      (alpha_q16),
      .inv_period_q16 (inv_period_q16)
   );

   // Sequencer.
   dema_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_bus.valid),
      .in_ready (req_bus.ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   // Arithmetic and state.
   dema_dp #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .sample         (req_bus.sample),
      .sample_valid   (req_bus.sample_valid),
      .period_length  (period_length),
      .alpha_q16      (alpha_q16),
      .inv_period_q16 (inv_period_q16),
      .cmd            (cmd),
      .stat           (stat),
      .out_valid      (rsp_bus.valid),
      .out_ready      (rsp_bus.ready),
      .dema_value     (rsp_bus.dema_value),
      .dema_valid     (rsp_bus.dema_valid)
   );

endmodule

// ===== rtl/dema_csr.sv =====
// -----------------------------------------------------------------------------
// Double EMA filter configuration registers
// APB-style register file for the seed period, alpha and the period reciprocal.
// -----------------------------------------------------------------------------
module dema_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [dema_pkg::ADDR_WIDTH-1:0]      paddr,
   input  logic [dema_pkg::DATA_WIDTH-1:0]      pwdata,
   output logic [dema_pkg::DATA_WIDTH-1:0]      prdata,
   output logic                                 pready,
   output logic [dema_pkg::PERIOD_WIDTH-1:0]    period_length,
   output logic [dema_pkg::COEF_WIDTH-1:0]      alpha_q16,
   output logic [dema_pkg::COEF_WIDTH-1:0]      inv_period_q16
);

   logic [dema_pkg::PERIOD_WIDTH-1:0]    period_ff;
   logic [dema_pkg::COEF_WIDTH-1:0]      alpha_ff;
   logic [dema_pkg::COEF_WIDTH-1:0]      inv_ff;
   logic [dema_pkg::REG_INDEX_WIDTH-1:0] index;
   logic                                 write_en;

   // The port never stalls.
   assign pready   = 1'b1;
   assign index    = paddr[dema_pkg::ADDR_WIDTH-1:2];
   assign write_en = psel && penable && pwrite;

   // Register writes land in the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= dema_pkg::PERIOD_RESET;
         alpha_ff  <= dema_pkg::ALPHA_RESET;
         inv_ff    <= dema_pkg::INV_PERIOD_RESET;
      end else if (write_en) begin
         case (index)
            dema_pkg::REG_PERIOD:     period_ff <= pwdata[dema_pkg::PERIOD_WIDTH-1:0];
            dema_pkg::REG_ALPHA:      alpha_ff  <= pwdata[dema_pkg::COEF_WIDTH-1:0];
            dema_pkg::REG_INV_PERIOD: inv_ff    <= pwdata[dema_pkg::COEF_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Read mux; unmapped addresses read as zero.
   always_comb begin
      case (index)
         dema_pkg::REG_PERIOD:     prdata = dema_pkg::DATA_WIDTH'(period_ff);
         dema_pkg::REG_ALPHA:      prdata = dema_pkg::DATA_WIDTH'(alpha_ff);
         dema_pkg::REG_INV_PERIOD: prdata = dema_pkg::DATA_WIDTH'(inv_ff);
         default:                  prdata = '0;
      endcase
   end

   assign period_length  = period_ff;
   assign alpha_q16      = alpha_ff;
   assign inv_period_q16 = inv_ff;

endmodule

// ===== rtl/dema_ctrl.sv =====
// -----------------------------------------------------------------------------
// Double EMA filter controller
// Sequences one item through the two EMA stages on the shared multiplier and
// hands the result to the output register.
// -----------------------------------------------------------------------------
`include "double_ema_filter_assert.svh"

module dema_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  dema_pkg::dema_stat_type stat,
   output dema_pkg::dema_cmd_type  cmd
);

   typedef enum logic [2:0] {
      IDLE,
      S1_PREP,
      S1_MUL,
      S1_RND,
      S2_PREP,
      S2_MUL,
      S2_RND,
      DONE
   } state_type;

   state_type state_ff, state_in;
   logic      ok_ff, ok_in;

   // Next state and result validity.
   always_comb begin
      state_in = state_ff;
      ok_in    = ok_ff;
      case (state_ff)
         IDLE: begin
            if (in_valid) begin
               state_in = S1_PREP;
               ok_in    = 1'b0;
            end
         end
         S1_PREP: begin
            if (stat.sample_ok && (stat.seeded || stat.seed_now)) begin
               state_in = S1_MUL;
            end else begin
               state_in = DONE;
            end
         end
         S1_MUL: state_in = S1_RND;
         S1_RND: state_in = S2_PREP;
         S2_PREP: begin
            if (stat.seeded || stat.seed_now) begin
               state_in = S2_MUL;
            end else begin
               state_in = DONE;
            end
         end
         S2_MUL: state_in = S2_RND;
         S2_RND: begin
            state_in = DONE;
            ok_in    = 1'b1;
         end
         DONE: begin
            if (!stat.out_busy) begin
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   // State and result flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         ok_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ok_ff    <= ok_in;
      end
   end

   // Commands decoded from the state.
   assign in_ready     = (state_ff == IDLE);
   assign cmd.take     = (state_ff == IDLE) && in_valid;
   assign cmd.prep     = (state_ff == S1_PREP) || (state_ff == S2_PREP);
   assign cmd.mul      = (state_ff == S1_MUL) || (state_ff == S2_MUL);
   assign cmd.rnd      = (state_ff == S1_RND) || (state_ff == S2_RND);
   assign cmd.stage    = ((state_ff == S2_PREP) || (state_ff == S2_RND)) ?
                         dema_pkg::STAGE_TWO : dema_pkg::STAGE_ONE;
   assign cmd.load_out = (state_ff == DONE) && !stat.out_busy;
   assign cmd.out_ok   = ok_ff;

   // An accepted beat always starts stage one next.
   `DEMA_ASSERT_NXT(a_take_starts, cmd.take, state_ff == S1_PREP, "take did not start stage one")
   // A result never overwrites one that is still waiting.
   `DEMA_ASSERT_IMP(a_load_free, cmd.load_out, !stat.out_busy, "result register overwritten")

endmodule

// ===== rtl/dema_dp.sv =====
// -----------------------------------------------------------------------------
// Double EMA filter datapath
// Stage counters and sums, the two EMA registers, one shared multiplier with
// rounding and saturation, and the result register.
// -----------------------------------------------------------------------------
`include "double_ema_filter_assert.svh"

module dema_dp #(
   parameter int SAMPLE_WIDTH = dema_pkg::DEFAULT_SAMPLE_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic signed [SAMPLE_WIDTH-1:0]       sample,
   input  logic                                 sample_valid,
   input  logic [dema_pkg::PERIOD_WIDTH-1:0]    period_length,
   input  logic [dema_pkg::COEF_WIDTH-1:0]      alpha_q16,
   input  logic [dema_pkg::COEF_WIDTH-1:0]      inv_period_q16,
   input  dema_pkg::dema_cmd_type               cmd,
   output dema_pkg::dema_stat_type              stat,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic signed [SAMPLE_WIDTH+1:0]       dema_value,
   output logic                                 dema_valid
);

   localparam int SUM_WIDTH  = SAMPLE_WIDTH + 10;
   localparam int OPB_WIDTH  = dema_pkg::COEF_WIDTH + 1;
   localparam int PROD_WIDTH = SUM_WIDTH + OPB_WIDTH;
   localparam int ACC_WIDTH  = PROD_WIDTH + 1;
   localparam int RND_WIDTH  = ACC_WIDTH - dema_pkg::FRAC_BITS;
   localparam int OUT_WIDTH  = SAMPLE_WIDTH + 2;
   localparam int PW         = dema_pkg::PERIOD_WIDTH;

   localparam logic signed [ACC_WIDTH-1:0] HALF_Q16 =
      ACC_WIDTH'(1) <<< (dema_pkg::FRAC_BITS - 1);

   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic                           sample_ok_ff;
   logic [PW-1:0]                  count1_ff, count2_ff;
   logic signed [SUM_WIDTH-1:0]    sum1_ff, sum2_ff;
   logic signed [SAMPLE_WIDTH-1:0] ema1_ff, ema2_ff;
   logic signed [SUM_WIDTH-1:0]    opa_ff;
   logic signed [OPB_WIDTH-1:0]    opb_ff;
   logic                           upd_ff;
   logic signed [PROD_WIDTH-1:0]   prod_ff;
   logic                           out_valid_ff;
   logic                           out_ok_ff;
   logic signed [OUT_WIDTH-1:0]    out_value_ff;

   logic [PW-1:0]                  eff_period;
   logic [dema_pkg::COEF_WIDTH-1:0] alpha_eff, inv_eff;
   logic signed [SAMPLE_WIDTH-1:0] x_sel, ema_sel;
   logic [PW-1:0]                  count_sel, count_next;
   logic signed [SUM_WIDTH-1:0]    sum_sel, sum_next, diff;
   logic                           seeded, seed_now, prep_en;
   logic signed [ACC_WIDTH-1:0]    ema_term, acc;
   logic [RND_WIDTH-1:0]           rounded;
   logic [RND_WIDTH-SAMPLE_WIDTH:0] top_bits;
   logic signed [SAMPLE_WIDTH-1:0] ema_new;
   logic signed [OUT_WIDTH-1:0]    dema_calc;

   // Clamp the configuration to its working ranges.
   always_comb begin
      if (period_length == '0) begin
         eff_period = PW'(1);
      end else if (period_length > dema_pkg::MAX_PERIOD) begin
         eff_period = dema_pkg::MAX_PERIOD;
      end else begin
         eff_period = period_length;
      end
      alpha_eff = (alpha_q16 > dema_pkg::ONE_Q16) ? dema_pkg::ONE_Q16 : alpha_q16;
      inv_eff   = (inv_period_q16 > dema_pkg::ONE_Q16) ? dema_pkg::ONE_Q16 : inv_period_q16;
   end

   // Stage selection: stage two runs on the fresh stage-one EMA.
   assign x_sel     = (cmd.stage == dema_pkg::STAGE_TWO) ? ema1_ff : sample_ff;
   assign ema_sel   = (cmd.stage == dema_pkg::STAGE_TWO) ? ema2_ff : ema1_ff;
   assign count_sel = (cmd.stage == dema_pkg::STAGE_TWO) ? count2_ff : count1_ff;
   assign sum_sel   = (cmd.stage == dema_pkg::STAGE_TWO) ? sum2_ff : sum1_ff;

   assign seeded     = (count_sel >= eff_period);
   assign count_next = count_sel + PW'(1);
   assign seed_now   = (count_next >= eff_period);
   assign sum_next   = sum_sel + SUM_WIDTH'(x_sel);
   assign diff       = SUM_WIDTH'(x_sel) - SUM_WIDTH'(ema_sel);
   assign prep_en    = cmd.prep && ((cmd.stage == dema_pkg::STAGE_TWO) || sample_ok_ff);

   // Input beat register.
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ok_ff <= 1'b0;
      end else if (cmd.take) begin
         sample_ok_ff <= sample_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         sample_ff <= sample;
      end
   end

   // Seeding counts and sums; a seeded stage leaves them alone.
   always_ff @(posedge clock) begin
      if (reset) begin
         count1_ff <= '0;
         count2_ff <= '0;
         sum1_ff   <= '0;
         sum2_ff   <= '0;
      end else if (prep_en && !seeded) begin
         if (cmd.stage == dema_pkg::STAGE_TWO) begin
            count2_ff <= count_next;
            sum2_ff   <= sum_next;
         end else begin
            count1_ff <= count_next;
            sum1_ff   <= sum_next;
         end
      end
   end

   // Multiplier operands: alpha*(x-ema) to update, sum*inv_period to seed.
   always_ff @(posedge clock) begin
      if (prep_en) begin
         if (seeded) begin
            opa_ff <= diff;
            opb_ff <= OPB_WIDTH'(alpha_eff);
            upd_ff <= 1'b1;
         end else begin
            opa_ff <= sum_next;
            opb_ff <= OPB_WIDTH'(inv_eff);
            upd_ff <= 1'b0;
         end
      end
   end

   // Shared multiplier.
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= opa_ff * opb_ff;
      end
   end

   // Add back ema*one for an update, round half up and saturate.
   always_comb begin
      ema_term = ACC_WIDTH'(ema_sel) <<< dema_pkg::FRAC_BITS;
      acc      = ACC_WIDTH'(prod_ff) + (upd_ff ? ema_term : '0) + HALF_Q16;
      rounded  = acc[ACC_WIDTH-1:dema_pkg::FRAC_BITS];
      top_bits = rounded[RND_WIDTH-1:SAMPLE_WIDTH-1];
      if ((&top_bits) || !(|top_bits)) begin
         ema_new = rounded[SAMPLE_WIDTH-1:0];
      end else begin
         ema_new = {rounded[RND_WIDTH-1], {(SAMPLE_WIDTH-1){~rounded[RND_WIDTH-1]}}};
      end
   end

   // EMA registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ema1_ff <= '0;
         ema2_ff <= '0;
      end else if (cmd.rnd) begin
         if (cmd.stage == dema_pkg::STAGE_TWO) begin
            ema2_ff <= ema_new;
         end else begin
            ema1_ff <= ema_new;
         end
      end
   end

   // DEMA = 2*ema1 - ema2, exact in two extra bits.
   assign dema_calc = {ema1_ff[SAMPLE_WIDTH-1], ema1_ff, 1'b0} -
                      {{2{ema2_ff[SAMPLE_WIDTH-1]}}, ema2_ff};

   // Result register; it frees the controller while a beat waits.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         out_ok_ff    <= 1'b0;
         out_value_ff <= '0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
         out_ok_ff    <= cmd.out_ok;
         out_value_ff <= cmd.out_ok ? dema_calc : '0;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign out_valid  = out_valid_ff;
   assign dema_valid = out_ok_ff;
   assign dema_value = out_value_ff;

   assign stat.sample_ok = sample_ok_ff;
   assign stat.seeded    = seeded;
   assign stat.seed_now  = seed_now;
   assign stat.out_busy  = out_valid_ff && !out_ready;

   // An invalid result always carries a zero value.
   `DEMA_ASSERT_IMP(a_invalid_zero, out_valid_ff && !out_ok_ff, out_value_ff == '0, "invalid result not zero")
   // Counts stop at the largest period.
   `DEMA_ASSERT_IMP(a_count_cap, 1'b1, (count1_ff <= dema_pkg::MAX_PERIOD) && (count2_ff <= dema_pkg::MAX_PERIOD), "stage count past limit")
   // Stage two only advances once stage one has produced a value.
   `DEMA_ASSERT_IMP(a_stage_order, count2_ff != '0, count1_ff != '0, "stage two ahead of stage one")

endmodule

// ===== bench/dema_checker.sv =====
// -----------------------------------------------------------------------------
// Double EMA filter checker
// Watches the configuration port and both channels. It keeps its own copy of
// the registers and of both EMA stages, works out the result of every accepted
// input beat, and compares each result beat with the oldest expected one.
// -----------------------------------------------------------------------------
module dema_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [dema_pkg::ADDR_WIDTH-1:0]  paddr,
   input  logic [dema_pkg::DATA_WIDTH-1:0]  pwdata,
   input  logic                             pready,
   dema_req_if                              req_mon,
   dema_rsp_if                              rsp_mon,
   output int                               pending,
   output int                               fail_count
);

   localparam longint SAMPLE_MAX = 64'sd2147483647;
   localparam longint SAMPLE_MIN = -64'sd2147483648;
   localparam longint HALF_LSB   = 64'sd32768;

   typedef struct {
      logic [33:0] value;
      logic        ok;
   } dema_beat_type;

   // Register copies.
   logic [dema_pkg::PERIOD_WIDTH-1:0] period_reg;
   logic [dema_pkg::COEF_WIDTH-1:0]   alpha_reg;
   logic [dema_pkg::COEF_WIDTH-1:0]   inv_period_reg;

   // Per-stage state; index 0 is the sample stage, index 1 the smoothing of it.
   logic [10:0]        seed_count [2];
   logic signed [41:0] seed_sum   [2];
   logic signed [31:0] stage_ema  [2];

   dema_beat_type expected_dema_q [$];

   // Coefficients above one saturate to one.
   function automatic longint clip_coef(input logic [dema_pkg::COEF_WIDTH-1:0] coef);
      return (coef > dema_pkg::ONE_Q16) ? longint'(dema_pkg::ONE_Q16) : longint'(coef);
   endfunction

   // Round a Q.32 product to nearest (ties upward) and clamp to the sample range.
   function automatic longint round_clamp(input longint prod);
      longint r;
      r = (prod + HALF_LSB) >>> 16;
      if (r > SAMPLE_MAX) r = SAMPLE_MAX;
      else if (r < SAMPLE_MIN) r = SAMPLE_MIN;
      return r;
   endfunction

   // Push one value through a stage. Returns 1 when the stage gives a value.
   function automatic bit advance_stage(input int s, input longint x, output longint y);
      longint span;
      longint a;
      longint acc;
      y = 0;
      if (period_reg == '0) span = 1;
      else if (period_reg > dema_pkg::MAX_PERIOD) span = longint'(dema_pkg::MAX_PERIOD);
      else span = longint'(period_reg);

      if (longint'(seed_count[s]) >= span) begin
         a = clip_coef(alpha_reg);
         acc = a * x + (longint'(dema_pkg::ONE_Q16) - a) * longint'(stage_ema[s]);
         stage_ema[s] = 32'(round_clamp(acc));
      end else begin
         seed_count[s] = seed_count[s] + 11'd1;
         seed_sum[s] = seed_sum[s] + 42'(x);
         if (longint'(seed_count[s]) < span) return 1'b0;
         stage_ema[s] = 32'(round_clamp(longint'(seed_sum[s]) * clip_coef(inv_period_reg)));
      end
      y = longint'(stage_ema[s]);
      return 1'b1;
   endfunction

   // Expected result of one input beat; updates the stage state.
   function automatic dema_beat_type predict_dema(input logic signed [31:0] sample,
                                                  input logic sample_ok);
      dema_beat_type beat;
      longint e1;
      longint e2;
      beat.value = '0;
      beat.ok = 1'b0;
      if (sample_ok) begin
         if (advance_stage(0, longint'(sample), e1)) begin
            if (advance_stage(1, e1, e2)) begin
               beat.value = 34'(2 * e1 - e2);
               beat.ok = 1'b1;
            end
         end
      end
      return beat;
   endfunction

   task automatic report_mismatch(input string what, input logic signed [63:0] got,
                                  input logic signed [63:0] want);
      $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      dema_beat_type want;
      if (reset) begin
         period_reg = dema_pkg::PERIOD_RESET;
         alpha_reg = dema_pkg::ALPHA_RESET;
         inv_period_reg = dema_pkg::INV_PERIOD_RESET;
         for (int s = 0; s < 2; s++) begin
            seed_count[s] = '0;
            seed_sum[s] = '0;
            stage_ema[s] = '0;
         end
         expected_dema_q.delete();
         fail_count = 0;
         pending <= 0;
      end else begin
         // Register writes land at the access cycle.
         if (psel && penable && pwrite && pready) begin
            case (paddr[dema_pkg::ADDR_WIDTH-1:2])
               dema_pkg::REG_PERIOD:     period_reg = pwdata[dema_pkg::PERIOD_WIDTH-1:0];
               dema_pkg::REG_ALPHA:      alpha_reg = pwdata[dema_pkg::COEF_WIDTH-1:0];
               dema_pkg::REG_INV_PERIOD: inv_period_reg = pwdata[dema_pkg::COEF_WIDTH-1:0];
               default: ;
            endcase
         end

         // Compare each result beat with the oldest expectation.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_dema_q.size() == 0) begin
               report_mismatch("unexpected result beat, dema_value",
                               $signed(rsp_mon.dema_value), 0);
            end else begin
               want = expected_dema_q.pop_front();
               if (rsp_mon.dema_valid !== want.ok)
                  report_mismatch("dema_valid", {63'd0, rsp_mon.dema_valid}, {63'd0, want.ok});
               if (rsp_mon.dema_value !== want.value)
                  report_mismatch("dema_value", $signed(rsp_mon.dema_value),
                                  $signed(want.value));
            end
         end

         // Work out the result of each accepted input beat.
         if (req_mon.valid && req_mon.ready)
            expected_dema_q.insert(expected_dema_q.size(),
                                   predict_dema(req_mon.sample, req_mon.sample_valid));

         pending <= expected_dema_q.size();
      end
   end

endmodule

// ===== bench/tb_double_ema_filter.sv =====
// -----------------------------------------------------------------------------
// Double EMA filter testbench
// Drives directed and random sample beats through several register settings,
// with random gaps on both channels and one long result stall, and leaves the
// checking to the checker instance.
// -----------------------------------------------------------------------------
module tb_double_ema_filter;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 20;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             psel;
   logic                             penable;
   logic                             pwrite;
   logic [dema_pkg::ADDR_WIDTH-1:0]  paddr;
   logic [dema_pkg::DATA_WIDTH-1:0]  pwdata;
   logic [dema_pkg::DATA_WIDTH-1:0]  prdata;
   logic                             pready;

   int                 pending;
   int                 fail_count;
   int                 cycle_count = 0;
   bit                 long_hold_due = 1'b0;
   logic signed [31:0] level = 32'sd6553600;

   dema_req_if req_bus ();
   dema_rsp_if rsp_bus ();

   double_ema_filter dut (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   dema_checker dema_check (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .pready     (pready),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .pending    (pending),
      .fail_count (fail_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // One register write: setup cycle, then access cycle.
   task automatic write_reg(input logic [dema_pkg::REG_INDEX_WIDTH-1:0] index,
                            input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock iff pready);
   endtask

   task automatic configure(input logic [31:0] period, input logic [31:0] alpha,
                            input logic [31:0] inv_period);
      write_reg(dema_pkg::REG_PERIOD, period);
      write_reg(dema_pkg::REG_ALPHA, alpha);
      write_reg(dema_pkg::REG_INV_PERIOD, inv_period);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Offer one sample beat after a random gap and wait until it is taken.
   task automatic send_beat(input logic [31:0] value, input logic ok);
      int gap;
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.sample <= value;
      req_bus.sample_valid <= ok;
      @(posedge clock iff req_bus.ready);
   endtask

   // Mostly a drifting price-like level with noise, sometimes raw or extreme values.
   function automatic logic [31:0] random_sample();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return $urandom();
      if (pick == 1) return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      level = level + (int'($urandom_range(0, 131072)) - 65536);
      return level + (int'($urandom_range(0, 4095)) - 2048);
   endfunction

   task automatic send_random_beats(input int count);
      repeat (count) send_beat(random_sample(), $urandom_range(0, 99) < 85);
   endtask

   // Stop offering and wait until every expected result has been taken.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock iff pending == 0);
   endtask

   // Result side: random stall before each beat, one long hold on request.
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (long_hold_due) begin
            stall = LONG_HOLD;
            long_hold_due = 1'b0;
         end else begin
            stall = $urandom_range(0, 1) ? 0 : $urandom_range(0, 17);
         end
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock iff rsp_bus.valid);
      end
   end

   // Stimulus and verdict.
   initial begin
      int span;
      logic [31:0] alpha;
      logic [31:0] inv_period;

      reset <= 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.sample <= '0;
      req_bus.sample_valid <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: skipped samples carrying extreme data, then field extremes.
      send_beat(32'h7fff_ffff, 1'b0);
      send_beat(32'h8000_0000, 1'b0);
      send_beat(32'h7fff_ffff, 1'b1);
      send_beat(32'h8000_0000, 1'b1);
      send_beat(32'h0000_0000, 1'b1);
      send_beat(32'h0000_0001, 1'b1);

      // Random beats with one long stall on the result side, so the input backs up.
      long_hold_due = 1'b1;
      send_random_beats(100);
      wait_drained();

      // Period raised past the count after seeding; coefficients above one.
      configure(32'd2047, 32'd131071, 32'd131071);
      repeat (8) send_beat(32'h7fff_ffff, 1'b1);
      wait_drained();

      // Reseed from a large kept sum: the mean saturates; alpha of zero holds the EMA.
      configure(32'd40, 32'd0, 32'd65536);
      repeat (3) send_beat(32'h7fff_ffff, 1'b1);
      wait_drained();

      // Period of zero acts as one, so any stage still seeding counts as seeded.
      configure(32'd0, 32'd65536, 32'd64);
      send_beat(32'h7fff_ffff, 1'b1);
      send_beat(32'h8000_0000, 1'b1);
      send_beat(32'h5a5a_a5a5, 1'b0);
      send_beat(32'h0001_0000, 1'b1);
      send_beat(32'hffff_0000, 1'b1);
      send_beat(32'h0000_0000, 1'b1);
      wait_drained();

      // Random settings: short periods mostly, one longer one at the end.
      for (int phase = 0; phase < 6; phase++) begin
         span = (phase == 5) ? 64 : $urandom_range(1, 24);
         if (phase % 2 == 1) alpha = $urandom_range(0, 65536);
         else alpha = (131072 + (span + 1) / 2) / (span + 1);
         if (phase == 3) inv_period = $urandom_range(64, 131071);
         else inv_period = (65536 + span / 2) / span;
         configure(span, alpha, inv_period);
         send_random_beats((phase == 5) ? 90 : 50);
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
